### rtl/afc_pkg.sv
// Shared types, codes and floating-point helpers for the approximate compare block.
`default_nettype none

package afc_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_TOLERANCE    = 2'd0;
  localparam logic [1:0] REG_CONSTANT     = 2'd1;
  localparam logic [1:0] REG_USE_CONSTANT = 2'd2;

  // Result codes, two's complement
  localparam logic [1:0] ORDER_EQUAL   = 2'b00;
  localparam logic [1:0] ORDER_GREATER = 2'b01;
  localparam logic [1:0] ORDER_LESS    = 2'b11;

  localparam logic [63:0] QUIET_NAN = 64'h7FF8_0000_0000_0000;
  localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;

  // Operands after swap and unpack, tolerance after normalization
  typedef struct packed {
    logic        special;
    logic [63:0] special_bits;
    logic        big_sign;
    logic        eff_sub;
    logic [52:0] big_sig;
    logic [52:0] small_sig;
    logic [10:0] big_exp;
    logic [10:0] exp_gap;
    logic        tol_pass;
    logic [63:0] tol_bits;
    logic [52:0] tol_sig;
    logic [12:0] tol_exp;
    logic [12:0] scale;
  } align_t;

  // Raw difference with guard/round/sticky, and the finished delta
  typedef struct packed {
    logic        special;
    logic [63:0] special_bits;
    logic        big_sign;
    logic [56:0] raw_sum;
    logic [10:0] big_exp;
    logic [63:0] delta;
  } norm_t;

  // Rounded difference and delta, ready to classify
  typedef struct packed {
    logic [63:0] diff;
    logic [63:0] delta;
  } cmp_t;

  function automatic logic [5:0] lead_zeros52(input logic [51:0] v);
    logic [5:0] n;
    logic       found;
    n     = 6'd52;
    found = 1'b0;
    for (int i = 51; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 6'(51 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [5:0] lead_zeros56(input logic [55:0] v);
    logic [5:0] n;
    logic       found;
    n     = 6'd56;
    found = 1'b0;
    for (int i = 55; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 6'(55 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic is_nan(input logic [63:0] x);
    return (x[62:52] == EXP_ALL_ONES) && (x[51:0] != 52'd0);
  endfunction

  // x < y as IEEE compares: false on NaN, signed zeros equal
  function automatic logic fp_less(input logic [63:0] x, input logic [63:0] y);
    logic both_zero;
    logic res;
    both_zero = (x[62:0] == 63'd0) && (y[62:0] == 63'd0);
    if (is_nan(x) || is_nan(y) || both_zero) begin
      res = 1'b0;
    end else if (x[63] != y[63]) begin
      res = x[63];
    end else if (!x[63]) begin
      res = x[62:0] < y[62:0];
    end else begin
      res = x[62:0] > y[62:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/approx_float_compare.sv
// Top level of the pipelined approximate binary64 compare.
// A transfer passes the input register and the operand, align, normalize and classify
// registers, five register stages, and then shows its result with done high.
// Throughput: one item per cycle, every cycle; busy stays low.
// Reset (rst, synchronous): clears the pipeline valid bits and all config registers.
// The result strobe done lasts one cycle; the receiver cannot stall the pipeline.
`default_nettype none

module approx_float_compare (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [63:0]       first_value,
  input  wire logic [63:0]       second_value,
  input  wire logic              cfg_write,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [63:0]       cfg_data,
  output logic                   done,
  output logic signed [1:0]      order
);
  import afc_pkg::*;

  // Configuration registers
  logic [63:0] tolerance;
  logic [63:0] constant_value;
  logic        use_constant;

  // Input register stage
  logic        in_valid;
  logic [63:0] a_reg;
  logic [63:0] b_reg;

  // Inter-stage payload
  logic    align_valid, norm_valid, cmp_valid;
  align_t  align_data;
  norm_t   norm_data;
  cmp_t    cmp_data;

  // No back-pressure anywhere: every stage advances every cycle.
  assign busy = 1'b0;

  // Write config only while no transfer is in flight; an index past the list drops
  // the write.
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance      <= 64'd0;
      constant_value <= 64'd0;
      use_constant   <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TOLERANCE:    tolerance      <= cfg_data;
        REG_CONSTANT:     constant_value <= cfg_data;
        REG_USE_CONSTANT: use_constant   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Capture the transfer; in constant mode the constant replaces the second value.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_reg <= first_value;
    b_reg <= use_constant ? constant_value : second_value;
  end

  // Stage 1: magnitude test, exponent source, operand swap, tolerance normalize
  afc_operand u_operand (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .a         (a_reg),
    .b         (b_reg),
    .tol       (tolerance),
    .out_valid (align_valid),
    .out       (align_data)
  );

  // Stage 2: align and add the difference; scale the tolerance into delta
  afc_align u_align (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (align_valid),
    .in        (align_data),
    .out_valid (norm_valid),
    .out       (norm_data)
  );

  // Stage 3: normalize and round the difference
  afc_normalize u_normalize (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (norm_valid),
    .in        (norm_data),
    .out_valid (cmp_valid),
    .out       (cmp_data)
  );

  // Stage 4: classify against plus and minus delta, drive the result strobe
  afc_classify u_classify (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmp_valid),
    .in       (cmp_data),
    .done     (done),
    .order    (order)
  );

`ifndef SYNTH
  // every accepted transfer yields one result
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##5 done)
    else $error("accepted transfer produced no result");

  // no result appears without a transfer behind it
  a_no_phantom : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 5))
    else $error("result without accepted transfer");

  // the unused two-bit code never leaves the block
  a_code : assert property (@(posedge clk) disable iff (rst)
    done |-> (order == ORDER_EQUAL || order == ORDER_GREATER || order == ORDER_LESS))
    else $error("invalid order code");

  // a NaN first value always classifies as equal
  a_nan_equal : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && first_value[62:52] == EXP_ALL_ONES && first_value[51:0] != 52'd0)
    |-> ##5 (done && order == ORDER_EQUAL))
    else $error("NaN operand gave nonzero order");
`endif

endmodule

`default_nettype wire

### rtl/afc_operand.sv
// Unpack stage: magnitude test, exponent source, operand swap, tolerance normalize.
`default_nettype none

module afc_operand (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic [63:0]     a,
  input  wire logic [63:0]     b,
  input  wire logic [63:0]     tol,
  output logic                 out_valid,
  output afc_pkg::align_t      out
);
  import afc_pkg::*;

  logic [63:0] nb;
  logic        a_nan, b_nan, a_inf, b_inf, a_bigger;
  logic [63:0] src, big, small_op;
  logic [5:0]  src_lz, tol_lz;
  logic [10:0] big_eff, small_eff;
  align_t      stage_next;

  always_comb begin
    nb       = {~b[63], b[62:0]};
    a_nan    = is_nan(a);
    b_nan    = is_nan(b);
    a_inf    = (a[62:52] == EXP_ALL_ONES) && (a[51:0] == 52'd0);
    b_inf    = (b[62:52] == EXP_ALL_ONES) && (b[51:0] == 52'd0);
    a_bigger = a[62:0] > b[62:0];

    // exponent source: a only when strictly larger and nothing is NaN
    src    = (!a_nan && !b_nan && a_bigger) ? a : b;
    src_lz = lead_zeros52(src[51:0]);
    if (src[62:52] == EXP_ALL_ONES) begin
      stage_next.scale = 13'd0;
    end else if (src[62:52] != 11'd0) begin
      stage_next.scale = 13'(src[62:52]) - 13'd1022;
    end else if (src[51:0] == 52'd0) begin
      stage_next.scale = 13'd0;
    end else begin
      stage_next.scale = 13'd0 - 13'd1022 - 13'(src_lz);
    end

    // difference as a + (-b), larger magnitude first
    big       = a_bigger ? a : nb;
    small_op  = a_bigger ? nb : a;
    big_eff   = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
    small_eff = (small_op[62:52] == 11'd0) ? 11'd1 : small_op[62:52];
    stage_next.big_sign  = big[63];
    stage_next.eff_sub   = big[63] ^ small_op[63];
    stage_next.big_sig   = {big[62:52] != 11'd0, big[51:0]};
    stage_next.small_sig = {small_op[62:52] != 11'd0, small_op[51:0]};
    stage_next.big_exp   = big_eff;
    stage_next.exp_gap   = big_eff - small_eff;

    priority if (a_nan || b_nan) begin
      stage_next.special      = 1'b1;
      stage_next.special_bits = QUIET_NAN;
    end else if (a_inf && b_inf) begin
      stage_next.special      = 1'b1;
      stage_next.special_bits = (a[63] == nb[63]) ? a : QUIET_NAN;
    end else if (a_inf) begin
      stage_next.special      = 1'b1;
      stage_next.special_bits = a;
    end else if (b_inf) begin
      stage_next.special      = 1'b1;
      stage_next.special_bits = nb;
    end else begin
      stage_next.special      = 1'b0;
      stage_next.special_bits = 64'd0;
    end

    // tolerance: zero, infinity and NaN pass through scaling unchanged
    tol_lz              = lead_zeros52(tol[51:0]);
    stage_next.tol_bits = tol;
    stage_next.tol_pass = (tol[62:52] == EXP_ALL_ONES) || (tol[62:0] == 63'd0);
    if (tol[62:52] != 11'd0) begin
      stage_next.tol_sig = {1'b1, tol[51:0]};
      stage_next.tol_exp = 13'(tol[62:52]) - 13'd1023;
    end else begin
      stage_next.tol_sig = {1'b0, tol[51:0]} << (7'(tol_lz) + 7'd1);
      stage_next.tol_exp = 13'd0 - 13'd1023 - 13'(tol_lz);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out <= stage_next;
  end

endmodule

`default_nettype wire

### rtl/afc_align.sv
// Align-and-add stage for the difference, and the power-of-two scaling of the tolerance.
`default_nettype none

module afc_align (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire afc_pkg::align_t in,
  output logic                 out_valid,
  output afc_pkg::norm_t       out
);
  import afc_pkg::*;

  logic [5:0]   gap_c;
  logic [111:0] ext;
  logic [55:0]  aligned, bigx;
  logic [12:0]  re, sh13;
  logic [5:0]   sh_c;
  logic [108:0] ext2;
  logic [52:0]  q;
  logic         round_up;
  logic [62:0]  mag;
  norm_t        stage_next;

  always_comb begin
    // align the smaller operand, fold everything shifted out into sticky
    gap_c   = (in.exp_gap > 11'd56) ? 6'd56 : in.exp_gap[5:0];
    ext     = {in.small_sig, 3'b000, 56'd0} >> gap_c;
    aligned = ext[111:56] | {55'd0, |ext[55:0]};
    bigx    = {in.big_sig, 3'b000};
    stage_next.raw_sum = in.eff_sub ? ({1'b0, bigx} - {1'b0, aligned})
                                    : ({1'b0, bigx} + {1'b0, aligned});
    stage_next.special      = in.special;
    stage_next.special_bits = in.special_bits;
    stage_next.big_sign     = in.big_sign;
    stage_next.big_exp      = in.big_exp;

    // delta = tolerance * 2^scale, round to nearest even in the subnormal range
    re       = in.tol_exp + in.scale;
    sh13     = 13'd0 - 13'd1022 - re;
    sh_c     = (sh13 > 13'd55) ? 6'd55 : sh13[5:0];
    ext2     = {in.tol_sig, 56'd0} >> sh_c;
    q        = ext2[108:56];
    round_up = ext2[55] & ((|ext2[54:0]) | q[0]);
    mag      = {11'd0, q[51:0]} + 63'(round_up);
    priority if (in.tol_pass) begin
      stage_next.delta = in.tol_bits;
    end else if ($signed(re) > 13'sd1023) begin
      stage_next.delta = {in.tol_bits[63], EXP_ALL_ONES, 52'd0};
    end else if ($signed(re) >= -13'sd1022) begin
      stage_next.delta = {in.tol_bits[63], 11'(re + 13'd1023), in.tol_sig[51:0]};
    end else begin
      stage_next.delta = {in.tol_bits[63], mag};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out <= stage_next;
  end

endmodule

`default_nettype wire

### rtl/afc_normalize.sv
// Normalize-and-round stage that turns the raw difference into a binary64 value.
`default_nettype none

module afc_normalize (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire afc_pkg::norm_t  in,
  output logic                 out_valid,
  output afc_pkg::cmp_t        out
);
  import afc_pkg::*;

  logic [56:0] r;
  logic [55:0] m;
  logic [11:0] ex, field;
  logic [5:0]  lz, sh;
  logic [10:0] max_sh;
  logic        round_up;
  logic [62:0] mag;
  cmp_t        stage_next;

  always_comb begin
    r      = in.raw_sum;
    lz     = lead_zeros56(r[55:0]);
    max_sh = in.big_exp - 11'd1;
    sh     = (11'(lz) < max_sh) ? lz : max_sh[5:0];
    if (r[56]) begin
      m  = {r[56:2], r[1] | r[0]};
      ex = 12'(in.big_exp) + 12'd1;
    end else begin
      // stop at the subnormal boundary
      m  = r[55:0] << sh;
      ex = 12'(in.big_exp) - 12'(sh);
    end
    field    = m[55] ? ex : 12'd0;
    round_up = m[2] & (m[1] | m[0] | m[3]);
    if (field == 12'd2047) begin
      mag = {EXP_ALL_ONES, 52'd0};
    end else begin
      mag = {field[10:0], m[54:3]} + 63'(round_up);
    end
    stage_next.diff  = in.special ? in.special_bits : {in.big_sign, mag};
    stage_next.delta = in.delta;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out <= stage_next;
  end

endmodule

`default_nettype wire

### rtl/afc_classify.sv
// Final stage: compare the difference against plus and minus delta.
`default_nettype none

module afc_classify (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire afc_pkg::cmp_t   in,
  output logic                 done,
  output logic signed [1:0]    order
);
  import afc_pkg::*;

  logic [63:0] neg_delta;
  logic [1:0]  order_next;

  always_comb begin
    neg_delta = {~in.delta[63], in.delta[62:0]};
    priority if (fp_less(in.delta, in.diff)) begin
      order_next = ORDER_GREATER;
    end else if (fp_less(in.diff, neg_delta)) begin
      order_next = ORDER_LESS;
    end else begin
      order_next = ORDER_EQUAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    order <= order_next;
  end

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for the approximate binary64 compare block.
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import afc_pkg::*;

  // The 2-bit index space has one slot past the register list; writes there do nothing
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam logic [63:0] POS_INF  = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] MAX_NORM = 64'h7FEF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN_SUB  = 64'h0000_0000_0000_0001;
  localparam logic [63:0] ONE      = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] EPS_REL  = 64'h3EB0_C6F7_A0B5_ED8D; // about 1e-6
  localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [63:0]       first_value;
  logic [63:0]       second_value;
  logic              cfg_write;
  logic [1:0]        cfg_index;
  logic [63:0]       cfg_data;
  logic              done;
  logic signed [1:0] order;

  // Mirror of the configuration registers
  logic [63:0] tol_reg;
  logic [63:0] const_reg;
  logic        const_mode;

  logic [1:0] pending_orders[$];
  int         errors;
  int         idle_pct;

  approx_float_compare u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .first_value (first_value),
    .second_value(second_value),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .done        (done),
    .order       (order)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Order predictor
  // ---------------------------------------------------------------------------
  function automatic logic bits_nan(input logic [63:0] x);
    return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
  endfunction

  // IEEE x > y on bit patterns: false with any NaN, and +0 equals -0
  function automatic logic bits_greater(input logic [63:0] x, input logic [63:0] y);
    if (bits_nan(x) || bits_nan(y)) return 1'b0;
    if (x[62:0] == 63'd0 && y[62:0] == 63'd0) return 1'b0;
    if (x[63] != y[63]) return y[63];
    if (!x[63]) return x[62:0] > y[62:0];
    return x[62:0] < y[62:0];
  endfunction

  // frexp exponent; zero, infinity and NaN give 0
  function automatic int frexp_exponent(input logic [63:0] x);
    int top;
    top = -1;
    if (x[62:52] == 11'h7FF) return 0;
    if (x[62:52] != 11'd0) return int'(x[62:52]) - 1022;
    if (x[51:0] == 52'd0) return 0;
    for (int k = 51; k >= 0; k--) begin
      if (top < 0 && x[k]) top = k;
    end
    return top - 1073;
  endfunction

  function automatic real two_to(input int n);
    logic [10:0] field;
    field = 11'(1023 + n);
    return $bitstoreal({1'b0, field, 52'd0});
  endfunction

  // tolerance * 2^n, split into steps so the final rounding happens only once
  function automatic logic [63:0] scaled_tolerance(input logic [63:0] tol, input int n);
    real y;
    y = $bitstoreal(tol);
    if (n > 1023) begin
      y = y * two_to(1023);
      n -= 1023;
      if (n > 1023) begin
        y = y * two_to(1023);
        n -= 1023;
        if (n > 1023) n = 1023;
      end
    end else if (n < -1022) begin
      y = y * two_to(-969);
      n += 969;
      if (n < -1022) begin
        y = y * two_to(-969);
        n += 969;
        if (n < -1022) n = -1022;
      end
    end
    return $realtobits(y * two_to(n));
  endfunction

  function automatic logic [1:0] predict_order(input logic [63:0] a, input logic [63:0] b_in);
    logic [63:0] b;
    logic [63:0] src;
    logic [63:0] delta;
    logic [63:0] diff;
    logic        a_bigger;
    b        = const_mode ? const_reg : b_in;
    a_bigger = !bits_nan(a) && !bits_nan(b) && (a[62:0] > b[62:0]);
    src      = a_bigger ? a : b;
    delta    = scaled_tolerance(tol_reg, frexp_exponent(src));
    diff     = $realtobits($bitstoreal(a) - $bitstoreal(b));
    if (bits_greater(diff, delta)) return ORDER_GREATER;
    if (bits_greater(delta ^ SIGN_BIT, diff)) return ORDER_LESS;
    return ORDER_EQUAL;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every strobe must match the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_orders.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual order=%0d", $time, order);
        errors++;
      end else begin
        logic [1:0] want;
        want = pending_orders.pop_front();
        if (order !== want) begin
          $display("%0t: order mismatch, expected=%b actual=%b", $time, want, order);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving helpers
  // ---------------------------------------------------------------------------
  // Write one register; the block must be idle
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    case (idx)
      REG_TOLERANCE:    tol_reg = val;
      REG_CONSTANT:     const_reg = val;
      REG_USE_CONSTANT: const_mode = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Hold start until the transfer, predict, then maybe drop start for a gap
  task automatic send_item(input logic [63:0] a, input logic [63:0] b);
    @(negedge clk);
    start        = 1'b1;
    first_value  = a;
    second_value = b;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_orders.push_back(predict_order(a, b));
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
  endtask

  // Wait for all results, then let the pipeline run empty
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_orders.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Half the time values near a pivot, else random patterns or special values
  function automatic logic [63:0] pick_value(input logic [63:0] pivot);
    case ($urandom_range(9))
      0, 1:    return rand64();
      2:       return {1'($urandom_range(1)), 11'h7FF,
                       ($urandom_range(1) ? 52'd0 : 52'(rand64()))};
      3:       return {1'($urandom_range(1)), 11'd0, 52'(rand64() >> $urandom_range(52))};
      4:       return {1'($urandom_range(1)), 63'd0};
      default: return pivot + 64'(signed'(32'($urandom_range(2000)) - 1000))
                      ^ (64'($urandom_range(1)) << 63);
    endcase
  endfunction

  task automatic random_pairs(input int count);
    logic [63:0] a;
    for (int i = 0; i < count; i++) begin
      a = ($urandom_range(3) == 0) ? rand64() : {1'b0, 11'($urandom_range(900, 1150)), 52'(rand64())};
      send_item(a, pick_value(a));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    write_reg(REG_TOLERANCE, EPS_REL);
    write_reg(REG_SPARE, rand64());
    send_item(64'd0, 64'd0);
    send_item(64'd0, SIGN_BIT);
    send_item(ONE, ONE + 64'd1);             // within tolerance
    send_item(ONE, 64'h3FF0_1000_0000_0000); // less
    send_item(64'h4000_0000_0000_0000, ONE); // greater
    send_item(POS_INF, POS_INF);             // inf - inf is NaN
    send_item(POS_INF | SIGN_BIT, POS_INF);
    send_item(POS_INF, MAX_NORM);
    send_item(QUIET_NAN, ONE);
    send_item(ONE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(MAX_NORM, MAX_NORM | SIGN_BIT); // overflow in diff
    send_item(MIN_SUB, 64'd0);
    send_item(MIN_SUB, MIN_SUB | SIGN_BIT);
    send_item(ONE | SIGN_BIT, ONE);           // magnitude tie
    send_item(64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    drain();
  endtask

  task automatic test_tolerance_extremes();
    logic [63:0] tols[8];
    tols = '{64'd0, MIN_SUB, EPS_REL, MAX_NORM, POS_INF, QUIET_NAN, EPS_REL | SIGN_BIT,
             64'h7FEF_0000_0000_0000};
    foreach (tols[t]) begin
      write_reg(REG_TOLERANCE, tols[t]);
      send_item(MAX_NORM, 64'h7FEF_FFFF_FFFF_FF00);
      send_item(MIN_SUB, 64'd2);
      send_item(ONE, ONE + 64'd7);
      random_pairs(40);
      drain();
    end
  endtask

  task automatic test_constant_mode();
    logic [63:0] consts[5];
    consts = '{64'd0, ONE, POS_INF, QUIET_NAN, 64'hFFFF_FFFF_FFFF_FFFF};
    write_reg(REG_TOLERANCE, EPS_REL);
    write_reg(REG_USE_CONSTANT, 64'hFFFF_FFFF_FFFF_FFFF);
    foreach (consts[c]) begin
      write_reg(REG_CONSTANT, consts[c]);
      send_item(consts[c], rand64());
      random_pairs(30);
      drain();
    end
    write_reg(REG_CONSTANT, {1'b0, 11'($urandom_range(1000, 1050)), 52'(rand64())});
    for (int i = 0; i < 120; i++) begin
      send_item(pick_value(const_reg), rand64());
    end
    drain();
    write_reg(REG_USE_CONSTANT, 64'd0);
  endtask

  // Random streams under three idle profiles, random tolerance per block
  task automatic test_random_streams();
    int pcts[3];
    pcts = '{23, 68, 0};
    foreach (pcts[p]) begin
      idle_pct = pcts[p];
      for (int blk = 0; blk < 5; blk++) begin
        write_reg(REG_TOLERANCE, ($urandom_range(3) == 0) ? rand64()
                  : {1'b0, 11'($urandom_range(950, 1030)), 52'(rand64())});
        random_pairs(100);
        drain();
      end
    end
  endtask

  initial begin
    errors       = 0;
    idle_pct     = 23;
    rst          = 1'b1;
    start        = 1'b0;
    first_value  = 64'd0;
    second_value = 64'd0;
    cfg_write    = 1'b0;
    cfg_index    = REG_TOLERANCE;
    cfg_data     = 64'd0;
    tol_reg      = 64'd0;
    const_reg    = 64'd0;
    const_mode   = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_tolerance_extremes();
    test_constant_mode();
    test_random_streams();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Safety net against a hung pipeline
  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/afc_pkg.sv
rtl/afc_operand.sv
rtl/afc_align.sv
rtl/afc_normalize.sv
rtl/afc_classify.sv
rtl/approx_float_compare.sv
dv/tb.sv
